>>> sv/sdel_pkg.sv
// Shared constants, codes, types and helpers of the sorted double-ended list.
`default_nettype none

package sdel_pkg;

    localparam int CAPACITY    = 32;
    localparam int MAX_RESULTS = 32;
    localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int KEY_W       = 32;
    localparam int MODE_W      = 4;
    localparam int STATUS_W    = 2;
    localparam int POS_W       = 5;
    localparam int COUNT_W     = 6;

    localparam logic [MODE_W-1:0] MODE_CLEAR    = 4'd0;
    localparam logic [MODE_W-1:0] MODE_INS_SORT = 4'd1;
    localparam logic [MODE_W-1:0] MODE_INS_TAIL = 4'd2;
    localparam logic [MODE_W-1:0] MODE_INS_HEAD = 4'd3;
    localparam logic [MODE_W-1:0] MODE_DEL_KEY  = 4'd4;
    localparam logic [MODE_W-1:0] MODE_DEL_TAIL = 4'd5;
    localparam logic [MODE_W-1:0] MODE_DEL_HEAD = 4'd6;
    localparam logic [MODE_W-1:0] MODE_REVERSE  = 4'd7;
    localparam logic [MODE_W-1:0] MODE_DUMP     = 4'd8;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd3;

    typedef struct packed {
        logic              lt;
        logic              eq;
    } cmp_res_t;

    typedef struct packed {
        logic              rd_en;
        logic [IDX_W-1:0]  rd_addr;
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        logic [KEY_W-1:0]  wr_data;
    } mem_req_t;

    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
        logic [KEY_W-1:0]    value;
        logic [POS_W-1:0]    position;
        logic [COUNT_W-1:0]  entry_count;
        logic                last;
    } res_t;

    // Zero-extend an entry index to the width of the entry count.
    function automatic logic [CNT_W-1:0] to_cnt(input logic [IDX_W-1:0] i);
        logic [CNT_W+IDX_W-1:0] t;
        t = {{CNT_W{1'b0}}, i};
        return t[CNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> sv/sorted_double_ended_list.sv
// Top level of the sorted double-ended list: stream ports, sequencer, store, output register.
`default_nettype none

// Bounded list of up to CAPACITY signed 32-bit keys, head at position 0, held
// in a single store with one write port and one registered read port. Each
// input item carries a mode and a key; every item yields one result, except a
// dump, which yields one result per entry (at most 32) with tlast on the final
// one. The block takes one item at a time: s_tready is high only while the
// sequencer is idle. A sorted insert runs a forward search, then, unless it
// lands at the tail, the upward shift; a head insert runs the upward shift
// alone; a key delete searches, then closes the gap with the downward shift,
// as a head delete does after taking its entry; a reverse swaps the entries
// pair by pair, and a dump reads back one entry per result. The store's single
// read port feeds the shared comparator and the shift moves at one entry a
// cycle. A finished result moves to the output register, so the next item can
// be taken while the result still waits for m_tready; a result that finds the
// output register still full waits until it drains.
module sorted_double_ended_list (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // mode[3:0], key[35:4], zero pad
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // status[1:0], value[33:2], position[38:34],
                                        // entry_count[44:39], zero pad
    output logic             m_tlast
);

    sdel_pkg::mem_req_t          mem_req;
    logic [sdel_pkg::KEY_W-1:0]  mem_rdata;
    sdel_pkg::res_t              res;
    logic                        res_ready;

    logic                        out_valid_reg;
    sdel_pkg::res_t              out_reg;

    sdel_mem u_mem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    sdel_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_mode   (s_tdata[3:0]),
        .in_key    (s_tdata[35:4]),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata),
        .res       (res),
        .res_ready (res_ready)
    );

    // Take a new result when the output register is empty or being drained.
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res.valid;
        end
    end

    // Hold the payload until the result is taken.
    always_ff @(posedge clk)
    begin
        if (res_ready && res.valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {3'b000, out_reg.entry_count, out_reg.position,
                       out_reg.value, out_reg.status};

endmodule

`default_nettype wire

>>> sv/sdel_cmp.sv
// Shared signed key comparator of the sorted double-ended list.
`default_nettype none

module sdel_cmp (
    input  wire logic signed [sdel_pkg::KEY_W-1:0] a,
    input  wire logic signed [sdel_pkg::KEY_W-1:0] b,
    output sdel_pkg::cmp_res_t                     res
);

    assign res.lt = (a < b);
    assign res.eq = (a == b);

endmodule

`default_nettype wire

>>> sv/sdel_mem.sv
// Entry store: one write port and one registered read port.
`default_nettype none

module sdel_mem (
    input  wire logic                         clk,
    input  wire sdel_pkg::mem_req_t           req,
    output logic     [sdel_pkg::KEY_W-1:0]    rdata
);

    logic [sdel_pkg::KEY_W-1:0] mem [sdel_pkg::CAPACITY];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rdata <= mem[req.rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> sv/sdel_ctrl.sv
// Sequencer: walks the entry store one entry a step through the shared comparator.
`default_nettype none

module sdel_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [sdel_pkg::MODE_W-1:0]   in_mode,
    input  wire logic [sdel_pkg::KEY_W-1:0]    in_key,
    output sdel_pkg::mem_req_t                 mem_req,
    input  wire logic [sdel_pkg::KEY_W-1:0]    mem_rdata,
    output sdel_pkg::res_t                     res,
    input  wire logic                          res_ready
);

    localparam int IDX_W = sdel_pkg::IDX_W;
    localparam int CNT_W = sdel_pkg::CNT_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_TAKE,
        S_DN_MOVE,
        S_UP_MOVE,
        S_WRITE_KEY,
        S_REV_RD_LO,
        S_REV_RD_HI,
        S_REV_WR_LO,
        S_REV_WR_HI,
        S_DUMP_RD,
        S_DUMP_OUT,
        S_EMIT
    } state_t;

    state_t                          state_reg,  state_next;
    logic [sdel_pkg::MODE_W-1:0]     mode_reg,   mode_next;
    logic [sdel_pkg::KEY_W-1:0]      key_reg,    key_next;
    logic [CNT_W-1:0]                total_reg,  total_next;
    logic [IDX_W-1:0]                pos_reg,    pos_next;
    logic [IDX_W-1:0]                idx_reg,    idx_next;
    logic [IDX_W-1:0]                hi_reg,     hi_next;
    logic [sdel_pkg::KEY_W-1:0]      tmp_reg,    tmp_next;
    logic [sdel_pkg::KEY_W-1:0]      value_reg,  value_next;
    logic [sdel_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic                            last_reg,   last_next;

    sdel_pkg::cmp_res_t              cmp;
    logic [CNT_W-1:0]                total_m1;
    logic [IDX_W-1:0]                total_m1_idx;
    logic                            is_full;
    logic                            is_empty;
    logic                            hit;
    logic [IDX_W+4:0]                idx_wide;
    logic [IDX_W+4:0]                pos_wide;
    logic [CNT_W+5:0]                cnt_wide;

    sdel_cmp u_cmp (
        .a   (mem_rdata),
        .b   (key_reg),
        .res (cmp)
    );

    assign total_m1     = CNT_W'(total_reg - 1'b1);
    assign total_m1_idx = total_m1[IDX_W-1:0];
    assign is_full      = (total_reg >= CNT_W'(sdel_pkg::CAPACITY));
    assign is_empty     = (total_reg == '0);
    assign hit          = (mode_reg == sdel_pkg::MODE_INS_SORT) ? !cmp.lt : cmp.eq;
    assign idx_wide     = {5'b0, idx_reg};
    assign pos_wide     = {5'b0, pos_reg};
    assign cnt_wide     = {6'b0, total_reg};

    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        key_next    = key_reg;
        total_next  = total_reg;
        pos_next    = pos_reg;
        idx_next    = idx_reg;
        hi_next     = hi_reg;
        tmp_next    = tmp_reg;
        value_next  = value_reg;
        status_next = status_reg;
        last_next   = last_reg;

        in_ready         = 1'b0;
        mem_req.rd_en    = 1'b0;
        mem_req.rd_addr  = '0;
        mem_req.wr_en    = 1'b0;
        mem_req.wr_addr  = '0;
        mem_req.wr_data  = mem_rdata;

        res.valid       = 1'b0;
        res.status      = status_reg;
        res.value       = value_reg;
        res.position    = pos_wide[4:0];
        res.entry_count = cnt_wide[5:0];
        res.last        = last_reg;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    mode_next   = in_mode;
                    key_next    = in_key;
                    value_next  = '0;
                    pos_next    = '0;
                    last_next   = 1'b1;
                    status_next = sdel_pkg::ST_OK;
                    state_next  = S_EMIT;
                    case (in_mode)
                        sdel_pkg::MODE_CLEAR:
                        begin
                            total_next = '0;
                        end
                        sdel_pkg::MODE_INS_SORT,
                        sdel_pkg::MODE_INS_TAIL,
                        sdel_pkg::MODE_INS_HEAD:
                        begin
                            if (is_full)
                            begin
                                status_next = sdel_pkg::ST_FULL;
                            end
                            else if (in_mode == sdel_pkg::MODE_INS_TAIL || is_empty)
                            begin
                                pos_next   = total_reg[IDX_W-1:0];
                                state_next = S_WRITE_KEY;
                            end
                            else if (in_mode == sdel_pkg::MODE_INS_HEAD)
                            begin
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = total_m1_idx;
                                idx_next        = total_reg[IDX_W-1:0];
                                state_next      = S_UP_MOVE;
                            end
                            else
                            begin
                                mem_req.rd_en = 1'b1;
                                idx_next      = '0;
                                state_next    = S_SEARCH;
                            end
                        end
                        sdel_pkg::MODE_DEL_KEY,
                        sdel_pkg::MODE_DEL_TAIL,
                        sdel_pkg::MODE_DEL_HEAD:
                        begin
                            if (is_empty)
                            begin
                                status_next = sdel_pkg::ST_EMPTY;
                            end
                            else if (in_mode == sdel_pkg::MODE_DEL_KEY)
                            begin
                                mem_req.rd_en = 1'b1;
                                idx_next      = '0;
                                state_next    = S_SEARCH;
                            end
                            else
                            begin
                                pos_next        = (in_mode == sdel_pkg::MODE_DEL_TAIL) ?
                                                  total_m1_idx : '0;
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = (in_mode == sdel_pkg::MODE_DEL_TAIL) ?
                                                  total_m1_idx : '0;
                                state_next      = S_TAKE;
                            end
                        end
                        sdel_pkg::MODE_REVERSE:
                        begin
                            if (total_reg > CNT_W'(1))
                            begin
                                idx_next   = '0;
                                hi_next    = total_m1_idx;
                                state_next = S_REV_RD_LO;
                            end
                        end
                        sdel_pkg::MODE_DUMP:
                        begin
                            if (is_empty)
                            begin
                                status_next = sdel_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_DUMP_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end

            // Data of entry idx is on the read port; fetch idx + 1 alongside.
            S_SEARCH:
            begin
                if (hit)
                begin
                    pos_next = idx_reg;
                    if (mode_reg == sdel_pkg::MODE_DEL_KEY)
                    begin
                        value_next = mem_rdata;
                        if (sdel_pkg::to_cnt(idx_reg) == total_m1)
                        begin
                            total_next = total_m1;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = IDX_W'(idx_reg + 1'b1);
                            state_next      = S_DN_MOVE;
                        end
                    end
                    else
                    begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = total_m1_idx;
                        idx_next        = total_reg[IDX_W-1:0];
                        state_next      = S_UP_MOVE;
                    end
                end
                else if (sdel_pkg::to_cnt(idx_reg) == total_m1)
                begin
                    if (mode_reg == sdel_pkg::MODE_DEL_KEY)
                    begin
                        status_next = sdel_pkg::ST_MISSING;
                        pos_next    = '0;
                        state_next  = S_EMIT;
                    end
                    else
                    begin
                        pos_next   = total_reg[IDX_W-1:0];
                        state_next = S_WRITE_KEY;
                    end
                end
                else
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = IDX_W'(idx_reg + 1'b1);
                    idx_next        = IDX_W'(idx_reg + 1'b1);
                end
            end

            S_TAKE:
            begin
                value_next = mem_rdata;
                idx_next   = pos_reg;
                if (sdel_pkg::to_cnt(pos_reg) == total_m1)
                begin
                    total_next = total_m1;
                    state_next = S_EMIT;
                end
                else
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = IDX_W'(pos_reg + 1'b1);
                    state_next      = S_DN_MOVE;
                end
            end

            // Close the gap: entry idx takes the entry above it.
            S_DN_MOVE:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = idx_reg;
                mem_req.wr_data = mem_rdata;
                if (CNT_W'(sdel_pkg::to_cnt(idx_reg) + 1'b1) == total_m1)
                begin
                    total_next = total_m1;
                    state_next = S_EMIT;
                end
                else
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = IDX_W'(idx_reg + 2'd2);
                    idx_next        = IDX_W'(idx_reg + 1'b1);
                end
            end

            // Open a gap: entry idx takes the entry below it.
            S_UP_MOVE:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = idx_reg;
                mem_req.wr_data = mem_rdata;
                if (IDX_W'(idx_reg - 1'b1) == pos_reg)
                begin
                    state_next = S_WRITE_KEY;
                end
                else
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = IDX_W'(idx_reg - 2'd2);
                    idx_next        = IDX_W'(idx_reg - 1'b1);
                end
            end

            S_WRITE_KEY:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = pos_reg;
                mem_req.wr_data = key_reg;
                total_next      = CNT_W'(total_reg + 1'b1);
                state_next      = S_EMIT;
            end

            S_REV_RD_LO:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = idx_reg;
                state_next      = S_REV_RD_HI;
            end

            S_REV_RD_HI:
            begin
                tmp_next        = mem_rdata;
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = hi_reg;
                state_next      = S_REV_WR_LO;
            end

            S_REV_WR_LO:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = idx_reg;
                mem_req.wr_data = mem_rdata;
                state_next      = S_REV_WR_HI;
            end

            S_REV_WR_HI:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = hi_reg;
                mem_req.wr_data = tmp_reg;
                if (CNT_W'(sdel_pkg::to_cnt(idx_reg) + 2'd2) < sdel_pkg::to_cnt(hi_reg))
                begin
                    idx_next   = IDX_W'(idx_reg + 1'b1);
                    hi_next    = IDX_W'(hi_reg - 1'b1);
                    state_next = S_REV_RD_LO;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end

            S_DUMP_RD:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = idx_reg;
                state_next      = S_DUMP_OUT;
            end

            S_DUMP_OUT:
            begin
                value_next  = mem_rdata;
                pos_next    = idx_reg;
                status_next = sdel_pkg::ST_OK;
                last_next   = (sdel_pkg::to_cnt(idx_reg) == total_m1) ||
                              (idx_wide == (IDX_W+5)'(sdel_pkg::MAX_RESULTS - 1));
                state_next  = S_EMIT;
            end

            S_EMIT:
            begin
                res.valid = 1'b1;
                if (res_ready)
                begin
                    if (last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = IDX_W'(idx_reg + 1'b1);
                        state_next = S_DUMP_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            mode_reg   <= sdel_pkg::MODE_CLEAR;
            key_reg    <= '0;
            total_reg  <= '0;
            pos_reg    <= '0;
            idx_reg    <= '0;
            hi_reg     <= '0;
            tmp_reg    <= '0;
            value_reg  <= '0;
            status_reg <= sdel_pkg::ST_OK;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            key_reg    <= key_next;
            total_reg  <= total_next;
            pos_reg    <= pos_next;
            idx_reg    <= idx_next;
            hi_reg     <= hi_next;
            tmp_reg    <= tmp_next;
            value_reg  <= value_next;
            status_reg <= status_next;
            last_reg   <= last_next;
        end
    end

endmodule

`default_nettype wire

>>> tb/sorted_double_ended_list_tb.sv
// Self-checking testbench for the sorted double-ended list: directed table, then random traffic.
`timescale 1ns / 100ps

module sorted_double_ended_list_tb;

    // Highest code the mode field can carry; codes above MODE_DUMP have no meaning.
    localparam logic [sdel_pkg::MODE_W-1:0] MODE_LAST_CODE = 4'd15;
    localparam logic [sdel_pkg::KEY_W-1:0]  KEY_MAX        = 32'h7FFF_FFFF;
    localparam logic [sdel_pkg::KEY_W-1:0]  KEY_MIN        = 32'h8000_0000;

    localparam int IDLE_PERCENT = 13;
    // Allow ample slack after the last result of a full dump.
    localparam int DRAIN_CYCLES = 3 * sdel_pkg::CAPACITY + 32;
    // Worst case is roughly 120 items of 32 results, each result stalled by back-pressure.
    localparam int CYCLE_LIMIT  = 400000;

    // One result as it appears on the master side.
    typedef struct packed {
        logic [sdel_pkg::STATUS_W-1:0] status;
        logic [sdel_pkg::KEY_W-1:0]    value;
        logic [sdel_pkg::POS_W-1:0]    position;
        logic [sdel_pkg::COUNT_W-1:0]  entry_count;
        logic                          last;
    } list_result_t;

    // One row of the directed table; fixed rows carry their result typed in.
    typedef struct packed {
        logic [sdel_pkg::MODE_W-1:0] mode;
        logic [sdel_pkg::KEY_W-1:0]  key;
        logic                        fixed;
        list_result_t                want;
    } script_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;      // mode[3:0], key[35:4], zero pad
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;           // status[1:0], value[33:2], position[38:34],
                                    // entry_count[44:39], zero pad
    logic        m_tlast;

    // Shadow copy of the list, head at index 0.
    logic [sdel_pkg::KEY_W-1:0] shadow_keys [sdel_pkg::CAPACITY];
    int                         shadow_total = 0;

    // Results of the most recent operation on the shadow list.
    list_result_t     step_results [sdel_pkg::MAX_RESULTS];
    int               step_total;

    list_result_t     awaited_results [$];
    script_row_t      directed_rows [$];

    int               error_count = 0;
    int               cycle_count = 0;
    logic             quiet_stretch = 1'b0;

    sorted_double_ended_list u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Build one result; the entry count is taken from the shadow list as it now stands.
    function automatic list_result_t make_result(
        input logic [sdel_pkg::STATUS_W-1:0] status,
        input logic [sdel_pkg::KEY_W-1:0] value,
        input int position,
        input logic last);
        list_result_t r;
        r.status      = status;
        r.value       = value;
        r.position    = position[sdel_pkg::POS_W-1:0];
        r.entry_count = shadow_total[sdel_pkg::COUNT_W-1:0];
        r.last        = last;
        return r;
    endfunction

    // Apply one operation to the shadow list and fill step_results with what it yields.
    function automatic void apply_list_op(input logic [sdel_pkg::MODE_W-1:0] mode,
                                          input logic [sdel_pkg::KEY_W-1:0] key);
        int                         i;
        int                         pos;
        int                         lo;
        int                         hi;
        int                         n;
        logic                       found;
        logic [sdel_pkg::KEY_W-1:0] removed;
        logic [sdel_pkg::KEY_W-1:0] swap;
        step_total = 1;
        case (mode)
            sdel_pkg::MODE_CLEAR:
            begin
                shadow_total = 0;
                step_results[0] = make_result(sdel_pkg::ST_OK, '0, 0, 1'b1);
            end
            sdel_pkg::MODE_INS_SORT, sdel_pkg::MODE_INS_TAIL, sdel_pkg::MODE_INS_HEAD:
            begin
                if (shadow_total >= sdel_pkg::CAPACITY)
                begin
                    step_results[0] = make_result(sdel_pkg::ST_FULL, '0, 0, 1'b1);
                end
                else
                begin
                    pos = (mode == sdel_pkg::MODE_INS_HEAD) ? 0 : shadow_total;
                    found = 1'b0;
                    // Sorted insert lands before the first entry not less than the key.
                    if (mode == sdel_pkg::MODE_INS_SORT)
                    begin
                        for (i = 0; i < shadow_total; i++)
                        begin
                            if (!found && !($signed(shadow_keys[i]) < $signed(key)))
                            begin
                                pos = i;
                                found = 1'b1;
                            end
                        end
                    end
                    for (i = shadow_total; i > pos; i--)
                        shadow_keys[i] = shadow_keys[i-1];
                    shadow_keys[pos] = key;
                    shadow_total++;
                    step_results[0] = make_result(sdel_pkg::ST_OK, '0, pos, 1'b1);
                end
            end
            sdel_pkg::MODE_DEL_KEY, sdel_pkg::MODE_DEL_TAIL, sdel_pkg::MODE_DEL_HEAD:
            begin
                if (shadow_total == 0)
                begin
                    step_results[0] = make_result(sdel_pkg::ST_EMPTY, '0, 0, 1'b1);
                end
                else
                begin
                    found = 1'b1;
                    pos = 0;
                    if (mode == sdel_pkg::MODE_DEL_TAIL)
                        pos = shadow_total - 1;
                    else if (mode == sdel_pkg::MODE_DEL_KEY)
                    begin
                        found = 1'b0;
                        for (i = 0; i < shadow_total; i++)
                        begin
                            if (!found && shadow_keys[i] == key)
                            begin
                                pos = i;
                                found = 1'b1;
                            end
                        end
                    end
                    if (!found)
                    begin
                        step_results[0] = make_result(sdel_pkg::ST_MISSING, '0, 0, 1'b1);
                    end
                    else
                    begin
                        removed = shadow_keys[pos];
                        for (i = pos; i + 1 < shadow_total; i++)
                            shadow_keys[i] = shadow_keys[i+1];
                        shadow_total--;
                        step_results[0] = make_result(sdel_pkg::ST_OK, removed, pos, 1'b1);
                    end
                end
            end
            sdel_pkg::MODE_REVERSE:
            begin
                lo = 0;
                hi = shadow_total - 1;
                while (lo < hi)
                begin
                    swap = shadow_keys[lo];
                    shadow_keys[lo] = shadow_keys[hi];
                    shadow_keys[hi] = swap;
                    lo++;
                    hi--;
                end
                step_results[0] = make_result(sdel_pkg::ST_OK, '0, 0, 1'b1);
            end
            sdel_pkg::MODE_DUMP:
            begin
                if (shadow_total == 0)
                begin
                    step_results[0] = make_result(sdel_pkg::ST_EMPTY, '0, 0, 1'b1);
                end
                else
                begin
                    // A dump reports at most MAX_RESULTS entries, from the head.
                    n = (shadow_total > sdel_pkg::MAX_RESULTS) ? sdel_pkg::MAX_RESULTS :
                                                                 shadow_total;
                    for (i = 0; i < n; i++)
                        step_results[i] = make_result(sdel_pkg::ST_OK, shadow_keys[i], i,
                                                      i == n - 1);
                    step_total = n;
                end
            end
            default:
            begin
                // Codes without meaning leave the list alone and answer ok.
                step_results[0] = make_result(sdel_pkg::ST_OK, '0, 0, 1'b1);
            end
        endcase
    endfunction

    // Key source: full random, a narrow band for duplicates, held keys, and extremes.
    function automatic logic [sdel_pkg::KEY_W-1:0] pick_key();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return $urandom;
        if (r < 6)
            return $urandom_range(0, 15) - 8;
        if (r < 8 && shadow_total != 0)
            return shadow_keys[$urandom_range(0, shadow_total - 1)];
        if (r == 8)
            return KEY_MAX;
        return KEY_MIN;
    endfunction

    task automatic add_row(input logic [sdel_pkg::MODE_W-1:0] mode,
                           input logic [sdel_pkg::KEY_W-1:0] key,
                           input logic fixed,
                           input logic [sdel_pkg::STATUS_W-1:0] status,
                           input logic [sdel_pkg::KEY_W-1:0] value,
                           input logic [sdel_pkg::POS_W-1:0] position,
                           input logic [sdel_pkg::COUNT_W-1:0] entry_count);
        script_row_t row;
        row.mode             = mode;
        row.key              = key;
        row.fixed            = fixed;
        row.want.status      = status;
        row.want.value       = value;
        row.want.position    = position;
        row.want.entry_count = entry_count;
        row.want.last        = 1'b1;
        directed_rows.push_back(row);
    endtask

    // Offer one item, hold it until taken, then log what it should yield.
    // Valid is only lowered inside the idle loop, so it never drops and rises in one step.
    task automatic send_list_op(input logic [sdel_pkg::MODE_W-1:0] mode,
                                input logic [sdel_pkg::KEY_W-1:0] key,
                                input logic fixed, input list_result_t want);
        int k;
        while (!quiet_stretch && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, key, mode};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        apply_list_op(mode, key);
        if (fixed)
            awaited_results.push_back(want);
        else
            for (k = 0; k < step_total; k++)
                awaited_results.push_back(step_results[k]);
    endtask

    // Drop valid and hold off until every logged result has come back.
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    // Result side: random back-pressure, checking, and the cycle watchdog.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (cycle_count > CYCLE_LIMIT)
        begin
            $display("sorted_double_ended_list_tb: errors");
            $finish;
        end
        else
        begin
            cycle_count <= cycle_count + 1;
            if (m_tvalid && m_tready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("unexpected result: status %0d value %0h position %0d count %0d",
                           m_tdata[1:0], m_tdata[33:2], m_tdata[38:34], m_tdata[44:39]);
                    error_count = error_count + 1;
                end
                else
                begin
                    list_result_t want;
                    want = awaited_results.pop_front();
                    if (m_tdata[1:0] !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, m_tdata[1:0]);
                        error_count = error_count + 1;
                    end
                    if (m_tdata[33:2] !== want.value)
                    begin
                        $error("value: expected %0h, got %0h", want.value, m_tdata[33:2]);
                        error_count = error_count + 1;
                    end
                    if (m_tdata[38:34] !== want.position)
                    begin
                        $error("position: expected %0d, got %0d", want.position,
                               m_tdata[38:34]);
                        error_count = error_count + 1;
                    end
                    if (m_tdata[44:39] !== want.entry_count)
                    begin
                        $error("entry_count: expected %0d, got %0d", want.entry_count,
                               m_tdata[44:39]);
                        error_count = error_count + 1;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, m_tlast);
                        error_count = error_count + 1;
                    end
                end
            end
            m_tready <= quiet_stretch || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    initial
    begin
        int                          item;
        int unsigned                 r;
        logic [sdel_pkg::MODE_W-1:0] op_mode;
        script_row_t                 row;

        // Empty list: every delete and the dump report empty, reverse is still ok.
        add_row(sdel_pkg::MODE_DUMP,     '0,      1'b1, sdel_pkg::ST_EMPTY, '0, 5'd0, 6'd0);
        add_row(sdel_pkg::MODE_DEL_HEAD, '0,      1'b1, sdel_pkg::ST_EMPTY, '0, 5'd0, 6'd0);
        add_row(sdel_pkg::MODE_DEL_TAIL, '0,      1'b1, sdel_pkg::ST_EMPTY, '0, 5'd0, 6'd0);
        add_row(sdel_pkg::MODE_DEL_KEY,  KEY_MAX, 1'b1, sdel_pkg::ST_EMPTY, '0, 5'd0, 6'd0);
        add_row(sdel_pkg::MODE_REVERSE,  '0,      1'b1, sdel_pkg::ST_OK,    '0, 5'd0, 6'd0);
        // Key extremes, and reverse of a lone entry.
        add_row(sdel_pkg::MODE_INS_SORT, KEY_MAX, 1'b1, sdel_pkg::ST_OK,    '0, 5'd0, 6'd1);
        add_row(sdel_pkg::MODE_REVERSE,  '0,      1'b1, sdel_pkg::ST_OK,    '0, 5'd0, 6'd1);
        add_row(sdel_pkg::MODE_INS_SORT, KEY_MIN, 1'b1, sdel_pkg::ST_OK,    '0, 5'd0, 6'd2);
        // Build a mixed list, then walk it with every remaining mode.
        add_row(sdel_pkg::MODE_INS_SORT, 32'h0000_0000, 1'b0, sdel_pkg::ST_OK, '0, 5'd0, 6'd0);
        add_row(sdel_pkg::MODE_INS_TAIL, 32'hFFFF_FFFF, 1'b0, sdel_pkg::ST_OK, '0, 5'd0, 6'd0);
        add_row(sdel_pkg::MODE_INS_HEAD, 32'hA5A5_A5A5, 1'b0, sdel_pkg::ST_OK, '0, 5'd0, 6'd0);
        add_row(sdel_pkg::MODE_INS_SORT, 32'hFFFF_FFFF, 1'b0, sdel_pkg::ST_OK, '0, 5'd0, 6'd0);
        add_row(sdel_pkg::MODE_DUMP,     '0,            1'b0, sdel_pkg::ST_OK, '0, 5'd0, 6'd0);
        // Missing key leaves all six entries in place.
        add_row(sdel_pkg::MODE_DEL_KEY,  32'h5A5A_5A5A, 1'b1, sdel_pkg::ST_MISSING, '0, 5'd0,
                6'd6);
        add_row(sdel_pkg::MODE_DEL_KEY,  32'hFFFF_FFFF, 1'b0, sdel_pkg::ST_OK, '0, 5'd0, 6'd0);
        add_row(sdel_pkg::MODE_REVERSE,  '0,            1'b0, sdel_pkg::ST_OK, '0, 5'd0, 6'd0);
        add_row(sdel_pkg::MODE_DUMP,     '0,            1'b0, sdel_pkg::ST_OK, '0, 5'd0, 6'd0);
        add_row(sdel_pkg::MODE_DEL_HEAD, '0,            1'b0, sdel_pkg::ST_OK, '0, 5'd0, 6'd0);
        add_row(sdel_pkg::MODE_DEL_TAIL, '0,            1'b0, sdel_pkg::ST_OK, '0, 5'd0, 6'd0);
        add_row(sdel_pkg::MODE_DUMP + 4'd1, 32'h5A5A_5A5A, 1'b0, sdel_pkg::ST_OK, '0, 5'd0,
                6'd0);
        add_row(MODE_LAST_CODE,          32'hFFFF_FFFF, 1'b0, sdel_pkg::ST_OK, '0, 5'd0, 6'd0);
        add_row(sdel_pkg::MODE_INS_TAIL, KEY_MIN,       1'b0, sdel_pkg::ST_OK, '0, 5'd0, 6'd0);
        add_row(sdel_pkg::MODE_DEL_KEY,  KEY_MIN,       1'b0, sdel_pkg::ST_OK, '0, 5'd0, 6'd0);
        add_row(sdel_pkg::MODE_CLEAR,    32'hFFFF_FFFF, 1'b1, sdel_pkg::ST_OK, '0, 5'd0, 6'd0);
        add_row(sdel_pkg::MODE_DUMP,     '0,            1'b1, sdel_pkg::ST_EMPTY, '0, 5'd0,
                6'd0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            send_list_op(row.mode, row.key, row.fixed, row.want);
        end

        // Mixed traffic: inserts slightly ahead of deletes keeps the list populated.
        for (item = 0; item < 10; item++)
        begin
            r = $urandom_range(0, 99);
            if (r < 20)
                op_mode = sdel_pkg::MODE_INS_SORT;
            else if (r < 32)
                op_mode = sdel_pkg::MODE_INS_TAIL;
            else if (r < 42)
                op_mode = sdel_pkg::MODE_INS_HEAD;
            else if (r < 56)
                op_mode = sdel_pkg::MODE_DEL_KEY;
            else if (r < 63)
                op_mode = sdel_pkg::MODE_DEL_TAIL;
            else if (r < 70)
                op_mode = sdel_pkg::MODE_DEL_HEAD;
            else if (r < 78)
                op_mode = sdel_pkg::MODE_REVERSE;
            else if (r < 88)
                op_mode = sdel_pkg::MODE_DUMP;
            else if (r < 91)
                op_mode = sdel_pkg::MODE_CLEAR;
            else
            begin
                r = $urandom_range(sdel_pkg::MODE_DUMP + 1, MODE_LAST_CODE);
                op_mode = r[sdel_pkg::MODE_W-1:0];
            end
            send_list_op(op_mode, pick_key(), 1'b0, '0);
        end

        hold_until_drained();

        // Fill to capacity with occasional noise, then push against the full list.
        // Run the fill with no idling on either side.
        quiet_stretch = 1'b1;
        while (shadow_total < sdel_pkg::CAPACITY)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                op_mode = sdel_pkg::MODE_INS_SORT;
            else if (r < 70)
                op_mode = sdel_pkg::MODE_INS_TAIL;
            else if (r < 92)
                op_mode = sdel_pkg::MODE_INS_HEAD;
            else if (r < 96)
                op_mode = sdel_pkg::MODE_DEL_KEY;
            else
                op_mode = sdel_pkg::MODE_DUMP;
            send_list_op(op_mode, pick_key(), 1'b0, '0);
        end
        quiet_stretch = 1'b0;
        send_list_op(sdel_pkg::MODE_INS_SORT, pick_key(), 1'b0, '0);
        send_list_op(sdel_pkg::MODE_INS_TAIL, pick_key(), 1'b0, '0);
        send_list_op(sdel_pkg::MODE_INS_HEAD, pick_key(), 1'b0, '0);
        send_list_op(sdel_pkg::MODE_DUMP, $urandom, 1'b0, '0);
        send_list_op(sdel_pkg::MODE_REVERSE, $urandom, 1'b0, '0);
        send_list_op(sdel_pkg::MODE_DUMP, $urandom, 1'b0, '0);
        send_list_op(sdel_pkg::MODE_DEL_KEY, $urandom, 1'b0, '0);

        hold_until_drained();

        // Drain mostly by key, with head and tail removals mixed in.
        while (shadow_total > 0)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                send_list_op(sdel_pkg::MODE_DEL_KEY,
                             shadow_keys[$urandom_range(0, shadow_total - 1)], 1'b0, '0);
            else if (r < 72)
                send_list_op(sdel_pkg::MODE_DEL_HEAD, $urandom, 1'b0, '0);
            else if (r < 89)
                send_list_op(sdel_pkg::MODE_DEL_TAIL, $urandom, 1'b0, '0);
            else if (r < 95)
                send_list_op(sdel_pkg::MODE_DUMP, $urandom, 1'b0, '0);
            else
                send_list_op(sdel_pkg::MODE_REVERSE, $urandom, 1'b0, '0);
        end
        send_list_op(sdel_pkg::MODE_DEL_KEY, pick_key(), 1'b0, '0);
        send_list_op(sdel_pkg::MODE_DEL_TAIL, $urandom, 1'b0, '0);
        send_list_op(sdel_pkg::MODE_DUMP, $urandom, 1'b0, '0);

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("sorted_double_ended_list_tb: clean");
        else
            $display("sorted_double_ended_list_tb: errors");
        $finish;
    end

endmodule
